/* design/lbs_pkg.sv */
package lbs_pkg;

    localparam int WORDS = 12;   // matrix words per joint, 3 rows x 4 columns
    localparam int SLOTS = 4;    // joints blended per vertex

    // blended matrix and position travelling from front to back
    typedef struct packed {
        logic [WORDS-1:0][31:0] mat;
        logic [2:0][31:0]       pos;
    } t_blend;

endpackage

/* design/lbs_ram.sv */
module lbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/lbs_front.sv */
module lbs_front #(
    parameter int JOINTS = 24,
    parameter int QDEPTH = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic                i_req_type,
    input  logic [4:0]          i_joint_a,
    input  logic [4:0]          i_joint_b,
    input  logic [4:0]          i_joint_c,
    input  logic [4:0]          i_joint_d,
    input  logic [15:0]         i_weight_a,
    input  logic [15:0]         i_weight_b,
    input  logic [15:0]         i_weight_c,
    input  logic [15:0]         i_weight_d,
    input  logic signed [31:0]  i_pos_x,
    input  logic signed [31:0]  i_pos_y,
    input  logic signed [31:0]  i_pos_z,
    input  logic                i_pop,
    output logic                o_push,
    output lbs_pkg::t_blend     o_item
);

    localparam int AW = $clog2(JOINTS);
    localparam int CW = $clog2(QDEPTH + 1);

    logic                          accept, ld, vx;
    logic [lbs_pkg::SLOTS-1:0][4:0]  jt;
    logic [lbs_pkg::SLOTS-1:0][15:0] wt;
    logic [31:0] rdata [lbs_pkg::SLOTS][lbs_pkg::WORDS];
    logic        we_lane [lbs_pkg::WORDS];
    logic        ja_ok;

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_v1, r_v2;
    logic [15:0]   r_w1 [lbs_pkg::SLOTS];
    logic          r_jv1 [lbs_pkg::SLOTS];
    logic [2:0][31:0] r_pos1, r_pos2;
    logic signed [48:0] prod [lbs_pkg::SLOTS][lbs_pkg::WORDS];
    logic signed [48:0] r_p2 [lbs_pkg::SLOTS][lbs_pkg::WORDS];

    assign jt = {i_joint_d, i_joint_c, i_joint_b, i_joint_a};
    assign wt = {i_weight_d, i_weight_c, i_weight_b, i_weight_a};

    // credit: vertices accepted and not yet popped from the queue
    assign o_stall = (r_cnt >= CW'(QDEPTH));
    assign accept  = i_valid && !o_stall;
    assign ld      = accept && !i_req_type;
    assign vx      = accept && i_req_type;
    assign ja_ok   = (int'(i_joint_a) < JOINTS);

    // one palette copy per slot, one lane per matrix word
    for (genvar c = 0; c < lbs_pkg::WORDS; c++) begin : g_lane
        assign we_lane[c] = ld && ja_ok && (int'(i_joint_b) == c);
        for (genvar k = 0; k < lbs_pkg::SLOTS; k++) begin : g_slot
            lbs_ram #(.WIDTH(32), .DEPTH(JOINTS)) u_ram (
                .i_clk   (i_clk),
                .i_we    (we_lane[c]),
                .i_waddr (AW'(i_joint_a)),
                .i_wdata (i_pos_x),
                .i_raddr (AW'(jt[k])),
                .o_rdata (rdata[k][c])
            );
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (vx && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!vx && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_comb begin
        for (int k = 0; k < lbs_pkg::SLOTS; k++) begin
            for (int c = 0; c < lbs_pkg::WORDS; c++) begin
                if (r_jv1[k]) begin
                    prod[k][c] = 49'($signed({1'b0, r_w1[k]})) * 49'($signed(rdata[k][c]));
                end else begin
                    prod[k][c] = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_v1  <= 1'b0;
            r_v2  <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_v1  <= vx;
            r_v2  <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < lbs_pkg::SLOTS; k++) begin
            r_w1[k]  <= wt[k];
            r_jv1[k] <= (int'(jt[k]) < JOINTS);
        end
        r_pos1 <= {i_pos_z, i_pos_y, i_pos_x};
        r_p2   <= prod;
        r_pos2 <= r_pos1;
    end

    // sum of four, round half up at 2^-15, saturate
    always_comb begin
        logic signed [50:0] s;
        logic signed [35:0] t;
        for (int c = 0; c < lbs_pkg::WORDS; c++) begin
            s = 51'(r_p2[0][c]) + 51'(r_p2[1][c]) + 51'(r_p2[2][c]) + 51'(r_p2[3][c])
                + 51'(16384);
            t = 36'(s >>> 15);
            if (t > 36'sd2147483647) begin
                o_item.mat[c] = 32'h7FFF_FFFF;
            end else if (t < -36'sd2147483648) begin
                o_item.mat[c] = 32'h8000_0000;
            end else begin
                o_item.mat[c] = t[31:0];
            end
        end
        o_item.pos = r_pos2;
    end

    assign o_push = r_v2;

endmodule

/* design/lbs_fifo.sv */
module lbs_fifo #(
    parameter int DEPTH = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lbs_pkg::t_blend i_data,
    input  logic            i_pop,
    output logic            o_valid,
    output lbs_pkg::t_blend o_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    lbs_pkg::t_blend r_mem [DEPTH];
    logic [AW-1:0]   r_wp, r_rp;
    logic [CW-1:0]   r_cnt;

    // no full check: the front holds a credit for every entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (int'(r_wp) == DEPTH - 1) ? '0 : r_wp + AW'(1);
            end
            if (i_pop) begin
                r_rp <= (int'(r_rp) == DEPTH - 1) ? '0 : r_rp + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

endmodule

/* design/lbs_back.sv */
module lbs_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  lbs_pkg::t_blend    i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z
);

    logic r_v1, r_ov, out_ready, adv1;
    logic signed [63:0] r_pr [3][3];
    logic signed [31:0] r_tr [3];
    logic [2:0][31:0]   r_out;
    logic [2:0][31:0]   res;

    assign out_ready = !r_ov || !i_stall;
    assign adv1      = !r_v1 || out_ready;
    assign o_pop     = i_valid && adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (out_ready) begin
                r_ov <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    r_pr[r][c] <= 64'($signed(i_item.mat[r*4+c]))
                                  * 64'($signed(i_item.pos[c]));
                end
                r_tr[r] <= $signed(i_item.mat[r*4+3]);
            end
        end
        if (out_ready && r_v1) begin
            r_out <= res;
        end
    end

    // exact row sum in Q.32, round half up to Q16.16, saturate
    always_comb begin
        logic signed [66:0] tot;
        logic signed [50:0] sh;
        for (int r = 0; r < 3; r++) begin
            tot = (67'(r_tr[r]) <<< 16) + 67'(r_pr[r][0]) + 67'(r_pr[r][1])
                  + 67'(r_pr[r][2]) + 67'(32768);
            sh = 51'(tot >>> 16);
            if (sh > 51'sd2147483647) begin
                res[r] = 32'h7FFF_FFFF;
            end else if (sh < -51'sd2147483648) begin
                res[r] = 32'h8000_0000;
            end else begin
                res[r] = sh[31:0];
            end
        end
    end

    assign o_valid = r_ov;
    assign o_out_x = $signed(r_out[0]);
    assign o_out_y = $signed(r_out[1]);
    assign o_out_z = $signed(r_out[2]);

endmodule

/* design/linear_blend_skinning.sv */
// Linear blend skinning, four joints per vertex.
// A vertex word passes the front pipeline, the queue, then the back's product and output registers to o_valid.
// Throughput: one word per cycle, loads and vertices alike, while the output is drained;
//   the front stalls only when QDEPTH vertices are accepted and not yet popped from the queue.
// Reset: synchronous, active low; clears pipeline valids, queue and credit count.
//   The palette is not cleared: each word is undefined until loaded.
module linear_blend_skinning #(
    parameter int JOINTS = 24,
    parameter int QDEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_req_type,
    input  logic [4:0]         i_joint_a,
    input  logic [4:0]         i_joint_b,
    input  logic [4:0]         i_joint_c,
    input  logic [4:0]         i_joint_d,
    input  logic [15:0]        i_weight_a,
    input  logic [15:0]        i_weight_b,
    input  logic [15:0]        i_weight_c,
    input  logic [15:0]        i_weight_d,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z
);

    // Front: load words write the palette at accept; vertex words read the
    // palette in the same edge (so order against loads is kept), weight the
    // four matrices and blend them. Back: matrix times (x, y, z, 1).
    lbs_pkg::t_blend push_item, q_item;
    logic            push, pop, q_valid;

    lbs_front #(.JOINTS(JOINTS), .QDEPTH(QDEPTH)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_joint_a  (i_joint_a),
        .i_joint_b  (i_joint_b),
        .i_joint_c  (i_joint_c),
        .i_joint_d  (i_joint_d),
        .i_weight_a (i_weight_a),
        .i_weight_b (i_weight_b),
        .i_weight_c (i_weight_c),
        .i_weight_d (i_weight_d),
        .i_pos_x    (i_pos_x),
        .i_pos_y    (i_pos_y),
        .i_pos_z    (i_pos_z),
        .i_pop      (pop),
        .o_push     (push),
        .o_item     (push_item)
    );

    // queue of blended vertices; sized by the front's credit count
    lbs_fifo #(.DEPTH(QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_item),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (q_item)
    );

    lbs_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_out_x (o_out_x),
        .o_out_y (o_out_y),
        .o_out_z (o_out_z)
    );

endmodule
